@@ sv/tspf_pkg.sv @@
// Shared types and constants for the textured span pixel fill block.
// Used by every module of the block except the RAM; depends on nothing.
`default_nettype none

package tspf_pkg;

   localparam int TEX_ADDR_BITS = 20;
   localparam int ROW_PIXELS    = 512;
   localparam int QUEUE_DEPTH   = 4;
   localparam int FRAME_ROWS    = 512;
   localparam int PIX_ADDR_BITS = 19;

   localparam logic [15:0] V_ROW_MASK = 16'hff00;

   localparam logic [1:0] CMD_TEX_WRITE = 2'd0;
   localparam logic [1:0] CMD_SPAN      = 2'd1;
   localparam logic [1:0] CMD_PIXEL     = 2'd2;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PALETTE_BASE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLAT_INDEX   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RENDER_MODE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DITHER_ON    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXTURE_PAGE = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DRAW_PAGE    = 3'd5;

   typedef enum logic [1:0] {
      MODE_FLAT        = 2'd0,
      MODE_TEXTURED    = 2'd1,
      MODE_TRANSPARENT = 2'd2,
      MODE_MASKED      = 2'd3
   } render_mode_type;

   // Settings the front end needs for addressing.
   typedef struct packed {
      logic [15:0] texture_page;
      logic        dither_on;
      logic        draw_page;
   } front_cfg_type;

   // Settings the back end needs for shading.
   typedef struct packed {
      logic [15:0]     palette_base;
      logic [7:0]      flat_index;
      render_mode_type render_mode;
   } back_cfg_type;

   // One classified pixel on its way to the back end.
   typedef struct packed {
      logic                     active;
      logic [PIX_ADDR_BITS-1:0] address;
      logic                     last;
      logic [7:0]               texel;
   } pixel_job_type;

endpackage

`default_nettype wire

@@ sv/tspf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module tspf_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(Depth)-1:0] write_addr,
   input  wire logic [Width-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(Depth)-1:0] read_addr,
   output logic      [Width-1:0]         read_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

@@ sv/tspf_queue.sv @@
// Short queue of classified pixels between the front and back ends.
// Depends on tspf_pkg for the pixel job type.
`default_nettype none

module tspf_queue #(
   parameter int Depth = tspf_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   input  wire tspf_pkg::pixel_job_type       push_job,
   input  wire logic                          pop,
   output logic                               out_valid,
   output tspf_pkg::pixel_job_type            out_job,
   output logic [$clog2(Depth+1)-1:0]         count
);

   localparam int PtrBits   = $clog2(Depth);
   localparam int CountBits = $clog2(Depth + 1);

   tspf_pkg::pixel_job_type entries_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_job   = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

@@ sv/tspf_front.sv @@
// Front end: accepts request words, keeps the span walker state, drives the
// texture memory ports and hands classified pixels to the queue. Uses tspf_pkg.
`default_nettype none

module tspf_front #(
   parameter int TexAddrBits = tspf_pkg::TEX_ADDR_BITS,
   parameter int RowPixels   = tspf_pkg::ROW_PIXELS,
   parameter int QueueDepth  = tspf_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tspf_pkg::front_cfg_type           cfg,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [18:0]                       req_texture_word_addr,
   input  wire logic [15:0]                       req_texture_word,
   input  wire logic [8:0]                        req_row,
   input  wire logic [8:0]                        req_span_start,
   input  wire logic [9:0]                        req_span_stop,
   input  wire logic signed [31:0]                req_u_start,
   input  wire logic signed [31:0]                req_v_start,
   input  wire logic signed [31:0]                req_u_step,
   input  wire logic signed [31:0]                req_v_step,
   output logic                                   ram_write_enable,
   output logic [TexAddrBits-2:0]                 ram_write_addr,
   output logic [15:0]                            ram_write_data,
   output logic                                   ram_read_enable,
   output logic [TexAddrBits-2:0]                 ram_read_addr,
   input  wire logic [15:0]                       ram_read_data,
   output logic                                   push_valid,
   output tspf_pkg::pixel_job_type                push_job,
   input  wire logic [$clog2(QueueDepth+1)-1:0]   queue_count
);

   localparam int XBits       = $clog2(RowPixels + 2);
   localparam int PixAddrBits = tspf_pkg::PIX_ADDR_BITS;
   localparam int CountBits   = $clog2(QueueDepth + 1);
   localparam int WordBits    = TexAddrBits - 1;
   localparam logic [PixAddrBits-1:0] PageStride =
      PixAddrBits'(tspf_pkg::FRAME_ROWS * RowPixels);

   // Span walker state.
   logic [XBits-1:0]       x_ff, x_in;
   logic [XBits-1:0]       stop_ff, stop_in;
   logic [1:0]             x_inc_ff, x_inc_in;
   logic [31:0]            u_ff, u_in, v_ff, v_in;
   logic [31:0]            du_ff, du_in, dv_ff, dv_in;
   logic [PixAddrBits-1:0] row_base_ff, row_base_in;
   logic                   active_ff, active_in;

   // Stage that waits for the texture read data.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_active_ff, s1_active_in;
   logic [PixAddrBits-1:0] s1_addr_ff, s1_addr_in;
   logic                   s1_last_ff, s1_last_in;
   logic                   s1_byte_ff, s1_byte_in;

   logic                   accept;
   logic                   is_pixel;
   logic                   parity;
   logic [XBits-1:0]       x_next;
   logic                   active_next;
   logic [PixAddrBits-1:0] pix_addr;
   logic [15:0]            v_row;
   logic [23:0]            u_col;
   logic [TexAddrBits-1:0] tex_addr;

   assign req_ready = ({1'b0, queue_count} + (CountBits + 1)'(s1_valid_ff))
                      < (CountBits + 1)'(QueueDepth);
   assign accept    = req_valid && req_ready;
   assign is_pixel  = accept && (req_cmd == tspf_pkg::CMD_PIXEL);

   // Texel address: page base, v row in the high byte, sign-extended u column.
   assign v_row    = v_ff[23:8] & tspf_pkg::V_ROW_MASK;
   assign u_col    = {{8{u_ff[31]}}, u_ff[31:16]};
   assign tex_addr = TexAddrBits'({cfg.texture_page, 8'h00})
                   + TexAddrBits'(v_row) + TexAddrBits'(u_col);

   assign x_next      = x_ff + XBits'(x_inc_ff);
   assign active_next = (x_next < stop_ff);
   assign pix_addr    = row_base_ff + (cfg.draw_page ? PageStride : '0)
                      + PixAddrBits'(x_ff);

   assign parity = cfg.dither_on && (req_row[0] ^ req_span_start[0]);

   always_comb begin
      x_in        = x_ff;
      stop_in     = stop_ff;
      x_inc_in    = x_inc_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      du_in       = du_ff;
      dv_in       = dv_ff;
      row_base_in = row_base_ff;
      active_in   = active_ff;
      if (accept) begin
         case (req_cmd)
            tspf_pkg::CMD_SPAN: begin
               // Dither aligns the start to the checkerboard and doubles the steps.
               x_in        = XBits'(req_span_start) + XBits'(parity);
               stop_in     = (int'(req_span_stop) > RowPixels) ? XBits'(RowPixels)
                                                              : XBits'(req_span_stop);
               u_in        = req_u_start + (parity ? req_u_step : 32'sd0);
               v_in        = req_v_start + (parity ? req_v_step : 32'sd0);
               du_in       = cfg.dither_on ? {req_u_step[30:0], 1'b0} : req_u_step;
               dv_in       = cfg.dither_on ? {req_v_step[30:0], 1'b0} : req_v_step;
               x_inc_in    = cfg.dither_on ? 2'd2 : 2'd1;
               row_base_in = PixAddrBits'(int'(req_row) * RowPixels);
               active_in   = (x_in < stop_in);
            end
            tspf_pkg::CMD_PIXEL: begin
               if (active_ff) begin
                  x_in      = x_next;
                  u_in      = u_ff + du_ff;
                  v_in      = v_ff + dv_ff;
                  active_in = active_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = is_pixel;
      s1_active_in = active_ff;
      s1_addr_in   = active_ff ? pix_addr : '0;
      s1_last_in   = active_ff ? !active_next : 1'b1;
      s1_byte_in   = tex_addr[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         stop_ff     <= '0;
         x_inc_ff    <= 2'd1;
         u_ff        <= '0;
         v_ff        <= '0;
         du_ff       <= '0;
         dv_ff       <= '0;
         row_base_ff <= '0;
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         x_ff        <= x_in;
         stop_ff     <= stop_in;
         x_inc_ff    <= x_inc_in;
         u_ff        <= u_in;
         v_ff        <= v_in;
         du_ff       <= du_in;
         dv_ff       <= dv_in;
         row_base_ff <= row_base_in;
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_active_ff <= s1_active_in;
         s1_addr_ff   <= s1_addr_in;
         s1_last_ff   <= s1_last_in;
         s1_byte_ff   <= s1_byte_in;
      end
   end

   // Texture loads go straight to memory; the byte pair never straddles a word.
   assign ram_write_enable = accept && (req_cmd == tspf_pkg::CMD_TEX_WRITE);
   assign ram_write_addr   = WordBits'(req_texture_word_addr);
   assign ram_write_data   = req_texture_word;
   assign ram_read_enable  = is_pixel && active_ff;
   assign ram_read_addr    = tex_addr[TexAddrBits-1:1];

   assign push_valid       = s1_valid_ff;
   assign push_job.active  = s1_active_ff;
   assign push_job.address = s1_addr_ff;
   assign push_job.last    = s1_last_ff;
   assign push_job.texel   = s1_byte_ff ? ram_read_data[15:8] : ram_read_data[7:0];

endmodule

`default_nettype wire

@@ sv/tspf_back.sv @@
// Back end: takes classified pixels from the queue, shades them by render
// mode and holds the result word for the response channel. Uses tspf_pkg.
`default_nettype none

module tspf_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tspf_pkg::back_cfg_type   cfg,
   input  wire logic                     queue_valid,
   input  wire tspf_pkg::pixel_job_type  queue_job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_pixel_write,
   output logic [18:0]                   rsp_pixel_address,
   output logic [15:0]                   rsp_pixel_value,
   output logic                          rsp_span_last
);

   logic        valid_ff, valid_in;
   logic        write_ff, write_in;
   logic [18:0] address_ff;
   logic [15:0] value_ff, value_in;
   logic        last_ff;

   logic        take;
   logic [15:0] flat_value;
   logic [15:0] texel_value;
   logic        texel_nonzero;

   assign take          = !valid_ff || rsp_ready;
   assign pop           = queue_valid && take;
   assign flat_value    = cfg.palette_base + {8'h00, cfg.flat_index};
   assign texel_value   = cfg.palette_base + {8'h00, queue_job.texel};
   assign texel_nonzero = (queue_job.texel != 8'h00);

   always_comb begin
      write_in = 1'b1;
      value_in = flat_value;
      case (cfg.render_mode)
         tspf_pkg::MODE_FLAT: begin
            value_in = flat_value;
         end
         tspf_pkg::MODE_TEXTURED: begin
            value_in = texel_value;
         end
         tspf_pkg::MODE_TRANSPARENT: begin
            write_in = texel_nonzero;
            value_in = texel_nonzero ? texel_value : 16'h0000;
         end
         tspf_pkg::MODE_MASKED: begin
            write_in = texel_nonzero;
            value_in = texel_nonzero ? flat_value : 16'h0000;
         end
         default: begin
            value_in = flat_value;
         end
      endcase
      if (!queue_job.active) begin
         write_in = 1'b0;
         value_in = 16'h0000;
      end
   end

   assign valid_in = take ? queue_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         write_ff   <= write_in;
         address_ff <= queue_job.address;
         value_ff   <= value_in;
         last_ff    <= queue_job.last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_pixel_write   = write_ff;
   assign rsp_pixel_address = address_ff;
   assign rsp_pixel_value   = value_ff;
   assign rsp_span_last     = last_ff;

endmodule

`default_nettype wire

@@ sv/textured_span_pixel_fill.sv @@
// Top level of the textured span pixel fill block: settings registers and
// the front end, texture RAM, pixel queue and back end. Uses tspf_pkg.
//
//   Channel | Direction | Handshake            | Carries
//   --------+-----------+----------------------+---------------------------------------
//   req_    | in        | req_valid/req_ready  | texture load, span setup or pixel step
//   rsp_    | out       | rsp_valid/rsp_ready  | one pixel word per pixel step
//   csr_    | in        | csr_write_enable     | settings register write, no wait
//
// The block takes one request word per clock while req_ready is high. A pixel
// step's word passes the registered texture RAM read, the pixel queue and the
// response register before it shows on the response channel. Reset clears the
// span state and settings; the texture RAM holds whatever it held and needs no
// clearing pass. When the response side stalls, the queue absorbs the words in
// flight and req_ready drops once it is full, counting the word in the read stage.
`default_nettype none

module textured_span_pixel_fill #(
   parameter int TexAddrBits = tspf_pkg::TEX_ADDR_BITS,
   parameter int RowPixels   = tspf_pkg::ROW_PIXELS,
   parameter int QueueDepth  = tspf_pkg::QUEUE_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [1:0]                             req_cmd,
   input  wire logic [18:0]                            req_texture_word_addr,
   input  wire logic [15:0]                            req_texture_word,
   input  wire logic [8:0]                             req_row,
   input  wire logic [8:0]                             req_span_start,
   input  wire logic [9:0]                             req_span_stop,
   input  wire logic signed [31:0]                     req_u_start,
   input  wire logic signed [31:0]                     req_v_start,
   input  wire logic signed [31:0]                     req_u_step,
   input  wire logic signed [31:0]                     req_v_step,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic                                        rsp_pixel_write,
   output logic [18:0]                                 rsp_pixel_address,
   output logic [15:0]                                 rsp_pixel_value,
   output logic                                        rsp_span_last,
   input  wire logic                                   csr_write_enable,
   input  wire logic [tspf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [15:0]                            csr_wdata
);

   localparam int WordDepth = 2 ** (TexAddrBits - 1);
   localparam int CountBits = $clog2(QueueDepth + 1);

   // Settings registers. The user must change them only while the block is idle
   // (the block does not enforce it), so both ends read them directly.
   logic [15:0]               palette_base_ff;
   logic [7:0]                flat_index_ff;
   tspf_pkg::render_mode_type render_mode_ff;
   logic                      dither_on_ff;
   logic [15:0]               texture_page_ff;
   logic                      draw_page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_base_ff <= '0;
         flat_index_ff   <= '0;
         render_mode_ff  <= tspf_pkg::MODE_FLAT;
         dither_on_ff    <= 1'b0;
         texture_page_ff <= '0;
         draw_page_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tspf_pkg::CSR_PALETTE_BASE: palette_base_ff <= csr_wdata;
            tspf_pkg::CSR_FLAT_INDEX:   flat_index_ff   <= csr_wdata[7:0];
            tspf_pkg::CSR_RENDER_MODE: begin
               render_mode_ff <= tspf_pkg::render_mode_type'(csr_wdata[1:0]);
            end
            tspf_pkg::CSR_DITHER_ON:    dither_on_ff    <= csr_wdata[0];
            tspf_pkg::CSR_TEXTURE_PAGE: texture_page_ff <= csr_wdata;
            tspf_pkg::CSR_DRAW_PAGE:    draw_page_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   tspf_pkg::front_cfg_type front_cfg;
   tspf_pkg::back_cfg_type  back_cfg;

   assign front_cfg.texture_page = texture_page_ff;
   assign front_cfg.dither_on    = dither_on_ff;
   assign front_cfg.draw_page    = draw_page_ff;
   assign back_cfg.palette_base  = palette_base_ff;
   assign back_cfg.flat_index    = flat_index_ff;
   assign back_cfg.render_mode   = render_mode_ff;

   logic                    ram_write_enable;
   logic [TexAddrBits-2:0]  ram_write_addr;
   logic [15:0]             ram_write_data;
   logic                    ram_read_enable;
   logic [TexAddrBits-2:0]  ram_read_addr;
   logic [15:0]             ram_read_data;

   logic                    push_valid;
   tspf_pkg::pixel_job_type push_job;
   logic                    queue_valid;
   tspf_pkg::pixel_job_type queue_job;
   logic                    queue_pop;
   logic [CountBits-1:0]    queue_count;

   tspf_front #(
      .TexAddrBits (TexAddrBits),
      .RowPixels   (RowPixels),
      .QueueDepth  (QueueDepth)
   ) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (front_cfg),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_texture_word_addr (req_texture_word_addr),
      .req_texture_word      (req_texture_word),
      .req_row               (req_row),
      .req_span_start        (req_span_start),
      .req_span_stop         (req_span_stop),
      .req_u_start           (req_u_start),
      .req_v_start           (req_v_start),
      .req_u_step            (req_u_step),
      .req_v_step            (req_v_step),
      .ram_write_enable      (ram_write_enable),
      .ram_write_addr        (ram_write_addr),
      .ram_write_data        (ram_write_data),
      .ram_read_enable       (ram_read_enable),
      .ram_read_addr         (ram_read_addr),
      .ram_read_data         (ram_read_data),
      .push_valid            (push_valid),
      .push_job              (push_job),
      .queue_count           (queue_count)
   );

   // Texture memory, one 16-bit word of two texels per entry.
   tspf_ram #(
      .Width (16),
      .Depth (WordDepth)
   ) u_texture_ram (
      .clock        (clock),
      .write_enable (ram_write_enable),
      .write_addr   (ram_write_addr),
      .write_data   (ram_write_data),
      .read_enable  (ram_read_enable),
      .read_addr    (ram_read_addr),
      .read_data    (ram_read_data)
   );

   tspf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (queue_pop),
      .out_valid  (queue_valid),
      .out_job    (queue_job),
      .count      (queue_count)
   );

   tspf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (back_cfg),
      .queue_valid       (queue_valid),
      .queue_job         (queue_job),
      .pop               (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_write   (rsp_pixel_write),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_span_last     (rsp_span_last)
   );

endmodule

`default_nettype wire

@@ dv/tb_textured_span_pixel_fill.sv @@
// Testbench for textured_span_pixel_fill: texture loads, span setups and pixel steps
// are driven on the request channel, and every pixel word is predicted and checked.
// Depends on tspf_pkg and the textured_span_pixel_fill RTL only.
`default_nettype none

module tb_textured_span_pixel_fill;

   // Command 3 has no meaning to the block; it must be swallowed without a word out.
   localparam logic [1:0] CMD_IGNORED = 2'd3;
   localparam int TEX_BYTES     = 1 << tspf_pkg::TEX_ADDR_BITS;
   localparam int CYCLE_LIMIT   = 400000;
   // The pipeline is three deep; this covers loads and setups that make no word.
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_CAP     = 100;

   // One request word, every field of the request channel.
   typedef struct {
      logic [1:0]  cmd;
      logic [18:0] word_addr;
      logic [15:0] tex_word;
      logic [8:0]  row;
      logic [8:0]  x_first;
      logic [9:0]  x_end;
      logic [31:0] u0;
      logic [31:0] v0;
      logic [31:0] du;
      logic [31:0] dv;
   } fill_word_type;

   // One pixel word as it should leave the response channel.
   typedef struct {
      logic        write;
      logic [18:0] address;
      logic [15:0] value;
      logic        last;
   } pixel_word_type;

   // All block inputs start at known values before the first clock edge.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_cmd = '0;
   logic [18:0]                req_texture_word_addr = '0;
   logic [15:0]                req_texture_word = '0;
   logic [8:0]                 req_row = '0;
   logic [8:0]                 req_span_start = '0;
   logic [9:0]                 req_span_stop = '0;
   logic signed [31:0]         req_u_start = '0;
   logic signed [31:0]         req_v_start = '0;
   logic signed [31:0]         req_u_step = '0;
   logic signed [31:0]         req_v_step = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_pixel_write;
   logic [18:0]                rsp_pixel_address;
   logic [15:0]                rsp_pixel_value;
   logic                       rsp_span_last;
   logic                       csr_write_enable = 1'b0;
   logic [tspf_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [15:0]                csr_wdata = '0;

   // Shadow of the texture RAM, plus a flag per byte that says it has been loaded.
   // A pixel step never reads a byte whose flag is still clear.
   bit [7:0]          tex_bytes [TEX_BYTES];
   bit                tex_known [TEX_BYTES];

   // Shadow of the span walker.
   logic [9:0]        px_x;
   logic [9:0]        px_stop;
   logic [1:0]        px_stride;
   logic [31:0]       u_acc;
   logic [31:0]       v_acc;
   logic [31:0]       u_inc;
   logic [31:0]       v_inc;
   logic [8:0]        px_row;
   logic              span_live;

   // Shadow of the settings registers.
   logic [15:0]               cfg_palette;
   logic [7:0]                cfg_flat;
   tspf_pkg::render_mode_type cfg_mode;
   logic                      cfg_dither;
   logic [15:0]               cfg_tex_page;
   logic                      cfg_draw_page;

   // Pixel words predicted at request acceptance, oldest first.
   pixel_word_type    pending_pixels [$];

   int                mismatches  = 0;
   int                words_sent  = 0;
   int                cycle_count = 0;
   // Percent chances that the sender idles or the receiver stalls on a cycle.
   int                idle_pct    = 0;
   int                stall_pct   = 0;

   textured_span_pixel_fill u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_texture_word_addr (req_texture_word_addr),
      .req_texture_word      (req_texture_word),
      .req_row               (req_row),
      .req_span_start        (req_span_start),
      .req_span_stop         (req_span_stop),
      .req_u_start           (req_u_start),
      .req_v_start           (req_v_start),
      .req_u_step            (req_u_step),
      .req_v_step            (req_v_step),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pixel_write       (rsp_pixel_write),
      .rsp_pixel_address     (rsp_pixel_address),
      .rsp_pixel_value       (rsp_pixel_value),
      .rsp_span_last         (rsp_span_last),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver drops ready at random, at the rate the current phase asks for.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung handshake or a lost word ends the run here.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
      end
   endtask

   // Every accepted pixel word is compared with the oldest prediction. Outputs are
   // sampled at the edge, before the block's own updates for that edge land.
   always @(posedge clock) begin : check_pixels
      pixel_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("pixel word with nothing pending", 32'(rsp_pixel_address), 0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_write !== want.write)
               report_mismatch("pixel_write", 32'(rsp_pixel_write), 32'(want.write));
            if (rsp_pixel_address !== want.address)
               report_mismatch("pixel_address", 32'(rsp_pixel_address), 32'(want.address));
            if (rsp_pixel_value !== want.value)
               report_mismatch("pixel_value", 32'(rsp_pixel_value), 32'(want.value));
            if (rsp_span_last !== want.last)
               report_mismatch("span_last", 32'(rsp_span_last), 32'(want.last));
         end
      end
   end

   task automatic reset_shadow();
      px_x          = '0;
      px_stop       = '0;
      px_stride     = 2'd1;
      u_acc         = '0;
      v_acc         = '0;
      u_inc         = '0;
      v_inc         = '0;
      px_row        = '0;
      span_live     = 1'b0;
      cfg_palette   = '0;
      cfg_flat      = '0;
      cfg_mode      = tspf_pkg::MODE_FLAT;
      cfg_dither    = 1'b0;
      cfg_tex_page  = '0;
      cfg_draw_page = 1'b0;
   endtask

   // Byte address of the texel under the current u, v. The integer part of u is
   // sign extended, v contributes its integer byte as the row, and the sum wraps
   // at the RAM size.
   function automatic logic [tspf_pkg::TEX_ADDR_BITS-1:0] texel_addr();
      logic [31:0] sum;
      sum = {8'h00, cfg_tex_page, 8'h00} + {16'h0000, v_acc[23:16], 8'h00}
          + {{16{u_acc[31]}}, u_acc[31:16]};
      return sum[tspf_pkg::TEX_ADDR_BITS-1:0];
   endfunction

   // Works out the word for one pixel step and walks the span one step on.
   function automatic pixel_word_type advance_pixel();
      pixel_word_type px;
      logic [7:0]     texel;
      logic [15:0]    flat;
      px = '{1'b0, 19'd0, 16'd0, 1'b1};
      if (!span_live) return px;
      texel      = tex_bytes[texel_addr()];
      flat       = cfg_palette + 16'(cfg_flat);
      px.write   = 1'b1;
      px.address = {cfg_draw_page, px_row, px_x[8:0]};
      case (cfg_mode)
         tspf_pkg::MODE_FLAT: begin
            px.value = flat;
         end
         tspf_pkg::MODE_TEXTURED: begin
            px.value = cfg_palette + 16'(texel);
         end
         tspf_pkg::MODE_TRANSPARENT: begin
            // A zero texel is a hole: nothing is written, but the address still shows.
            if (texel != 8'h00) px.value = cfg_palette + 16'(texel);
            else px.write = 1'b0;
         end
         default: begin
            // Masked: any nonzero texel paints the flat colour.
            if (texel != 8'h00) px.value = flat;
            else px.write = 1'b0;
         end
      endcase
      u_acc = u_acc + u_inc;
      v_acc = v_acc + v_inc;
      px_x  = px_x + 10'(px_stride);
      if (px_x >= px_stop) span_live = 1'b0;
      px.last = !span_live;
      return px;
   endfunction

   // Brings the shadow up to date with one accepted request word.
   task automatic apply_word(fill_word_type w);
      logic [tspf_pkg::TEX_ADDR_BITS-1:0] ba;
      logic [9:0]                         sx;
      logic [31:0]                        du;
      logic [31:0]                        dv;
      case (w.cmd)
         tspf_pkg::CMD_TEX_WRITE: begin
            ba = {w.word_addr, 1'b0};
            tex_bytes[ba]        = w.tex_word[7:0];
            tex_bytes[ba + 1'b1] = w.tex_word[15:8];
            tex_known[ba]        = 1'b1;
            tex_known[ba + 1'b1] = 1'b1;
         end
         tspf_pkg::CMD_SPAN: begin
            sx      = {1'b0, w.x_first};
            px_stop = (w.x_end > 10'(tspf_pkg::ROW_PIXELS)) ? 10'(tspf_pkg::ROW_PIXELS)
                                                            : w.x_end;
            px_row  = w.row;
            u_acc   = w.u0;
            v_acc   = w.v0;
            du      = w.du;
            dv      = w.dv;
            if (cfg_dither) begin
               // The checkerboard starts on the first pixel where row and x agree
               // in parity; the coordinates move one step to meet it.
               if (w.row[0] ^ sx[0]) begin
                  sx    = sx + 10'd1;
                  u_acc = u_acc + du;
                  v_acc = v_acc + dv;
               end
               du        = du << 1;
               dv        = dv << 1;
               px_stride = 2'd2;
            end else begin
               px_stride = 2'd1;
            end
            u_inc     = du;
            v_inc     = dv;
            px_x      = sx;
            span_live = (sx < px_stop);
         end
         tspf_pkg::CMD_PIXEL: begin
            pending_pixels.push_back(advance_pixel());
         end
         default: begin
         end
      endcase
   endtask

   // Sends one request word. Random idle cycles go first, then valid is held
   // with a steady payload until ready is seen at an edge. Valid is left high
   // on return; whoever waits next lowers it in that same time step.
   task automatic issue_word(fill_word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_cmd               <= w.cmd;
      req_texture_word_addr <= w.word_addr;
      req_texture_word      <= w.tex_word;
      req_row               <= w.row;
      req_span_start        <= w.x_first;
      req_span_stop         <= w.x_end;
      req_u_start           <= w.u0;
      req_v_start           <= w.v0;
      req_u_step            <= w.du;
      req_v_step            <= w.dv;
      req_valid             <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (w.cmd != CMD_IGNORED) words_sent++;
      apply_word(w);
   endtask

   // A word of the given command with every other field random, so that unused
   // fields toggle too.
   function automatic fill_word_type random_word(logic [1:0] cmd);
      fill_word_type w;
      w.cmd       = cmd;
      w.word_addr = 19'($urandom);
      w.tex_word  = 16'($urandom);
      w.row       = 9'($urandom);
      w.x_first   = 9'($urandom);
      w.x_end     = 10'($urandom);
      w.u0        = $urandom;
      w.v0        = $urandom;
      w.du        = $urandom;
      w.dv        = $urandom;
      return w;
   endfunction

   // Texels are zero often enough that holes and masks show up regularly.
   function automatic logic [7:0] texel_byte();
      return ($urandom_range(9) < 3) ? 8'h00 : 8'($urandom);
   endfunction

   // One pixel step. If the texel it is about to read was never loaded, the word
   // that holds it is loaded first with random texels.
   task automatic step_pixel();
      fill_word_type                      w;
      logic [tspf_pkg::TEX_ADDR_BITS-1:0] a;
      if (span_live) begin
         a = texel_addr();
         if (!tex_known[a]) begin
            w           = random_word(tspf_pkg::CMD_TEX_WRITE);
            w.word_addr = a[tspf_pkg::TEX_ADDR_BITS-1:1];
            w.tex_word  = {texel_byte(), texel_byte()};
            issue_word(w);
         end
      end
      issue_word(random_word(tspf_pkg::CMD_PIXEL));
   endtask

   task automatic open_span(logic [8:0] row, logic [8:0] first, logic [9:0] stop,
                            logic [31:0] u0, logic [31:0] v0,
                            logic [31:0] du, logic [31:0] dv);
      fill_word_type w;
      w         = random_word(tspf_pkg::CMD_SPAN);
      w.row     = row;
      w.x_first = first;
      w.x_end   = stop;
      w.u0      = u0;
      w.v0      = v0;
      w.du      = du;
      w.dv      = dv;
      issue_word(w);
   endtask

   task automatic load_texture(logic [18:0] word_addr, logic [15:0] data);
      fill_word_type w;
      w           = random_word(tspf_pkg::CMD_TEX_WRITE);
      w.word_addr = word_addr;
      w.tex_word  = data;
      issue_word(w);
   endtask

   // Holds the sender off until every predicted word is back, then lets the
   // pipeline settle so that loads and setups behind the last word are done too.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [tspf_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         tspf_pkg::CSR_PALETTE_BASE: cfg_palette   = data;
         tspf_pkg::CSR_FLAT_INDEX:   cfg_flat      = data[7:0];
         tspf_pkg::CSR_RENDER_MODE:  cfg_mode      = tspf_pkg::render_mode_type'(data[1:0]);
         tspf_pkg::CSR_DITHER_ON:    cfg_dither    = data[0];
         tspf_pkg::CSR_TEXTURE_PAGE: cfg_tex_page  = data;
         tspf_pkg::CSR_DRAW_PAGE:    cfg_draw_page = data[0];
         default: begin
         end
      endcase
   endtask

   // Rewrites all six settings once the block is idle. Unused upper data bits
   // carry junk, which the narrow registers must drop.
   task automatic configure(logic [15:0] palette, logic [7:0] flat,
                            tspf_pkg::render_mode_type mode,
                            logic dither, logic [15:0] page, logic draw);
      wait_quiet();
      write_csr(tspf_pkg::CSR_PALETTE_BASE, palette);
      write_csr(tspf_pkg::CSR_FLAT_INDEX, {8'($urandom), flat});
      write_csr(tspf_pkg::CSR_RENDER_MODE, {14'($urandom), mode});
      write_csr(tspf_pkg::CSR_DITHER_ON, {15'($urandom), dither});
      write_csr(tspf_pkg::CSR_TEXTURE_PAGE, page);
      write_csr(tspf_pkg::CSR_DRAW_PAGE, {15'($urandom), draw});
   endtask

   function automatic logic [15:0] pick_wide16();
      case ($urandom_range(3))
         0:       return 16'h0000;
         1:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic configure_random();
      logic [7:0] flat;
      case ($urandom_range(3))
         0:       flat = 8'h00;
         1:       flat = 8'hff;
         default: flat = 8'($urandom);
      endcase
      configure(pick_wide16(), flat, tspf_pkg::render_mode_type'($urandom_range(3)),
                1'($urandom), pick_wide16(), 1'($urandom));
   endtask

   // Start coordinates: half anywhere in the 16.16 range, half near the page.
   function automatic logic [31:0] pick_coord();
      return ($urandom_range(1) == 0) ? $urandom : {8'h00, 8'($urandom), 16'($urandom)};
   endfunction

   // Steps: mostly within a few texels per pixel, now and then anything.
   function automatic logic [31:0] pick_step(bit narrow);
      if (!narrow && $urandom_range(3) == 0) return $urandom;
      return 32'($urandom_range(32'h50000)) - 32'h28000;
   endfunction

   // A well-formed span: setup, then its pixels. Now and then it is cut short so
   // that the next setup replaces it, or stepped past its end into idle steps.
   task automatic random_span();
      logic [8:0] row;
      logic [8:0] first;
      logic [9:0] stop;
      int         len;
      int         cut;
      int         done;
      bit         wide;
      row   = 9'($urandom);
      first = 9'($urandom);
      wide  = ($urandom_range(49) == 0);
      len   = wide ? tspf_pkg::ROW_PIXELS : $urandom_range(12, 1);
      stop  = 10'({1'b0, first} + 10'(len));
      open_span(row, first, stop, pick_coord(), pick_coord(), pick_step(wide),
                pick_step(wide));
      cut  = ($urandom_range(9) == 0) ? $urandom_range(len) : tspf_pkg::ROW_PIXELS;
      // A full-row span is walked only partway so that it stays a small share
      // of the traffic.
      if (wide) cut = $urandom_range(32, 8);
      done = 0;
      while (span_live && done < cut) begin
         step_pixel();
         done++;
      end
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(2, 1)) step_pixel();
      end
   endtask

   // Odd traffic: loads anywhere in the RAM, ignored commands, stray steps,
   // spans with any field values and empty spans.
   task automatic random_noise();
      fill_word_type w;
      logic [8:0]    first;
      case ($urandom_range(4))
         0: begin
            issue_word(random_word(tspf_pkg::CMD_TEX_WRITE));
         end
         1: begin
            issue_word(random_word(CMD_IGNORED));
         end
         2: begin
            step_pixel();
         end
         3: begin
            issue_word(random_word(tspf_pkg::CMD_SPAN));
            repeat ($urandom_range(3)) step_pixel();
         end
         default: begin
            first = 9'($urandom);
            w = random_word(tspf_pkg::CMD_SPAN);
            w.x_first = first;
            w.x_end   = 10'($urandom_range(first));
            issue_word(w);
            step_pixel();
         end
      endcase
   endtask

   task automatic run_traffic(int budget);
      int stop_at;
      int next_cfg;
      stop_at  = words_sent + budget;
      next_cfg = words_sent;
      while (words_sent < stop_at) begin
         // Fresh settings every few dozen words; this also drains the block,
         // so the sender regularly waits for every outstanding word.
         if (words_sent >= next_cfg) begin
            configure_random();
            next_cfg = words_sent + $urandom_range(90, 40);
         end
         if ($urandom_range(99) < 85) random_span();
         else random_noise();
      end
   endtask

   // Straight out of reset: a step with no span, an ignored command, and an
   // empty span that must leave the walker idle.
   task automatic test_idle_and_ignored();
      step_pixel();
      issue_word(random_word(CMD_IGNORED));
      open_span(9'd100, 9'd100, 10'd100, 32'h0, 32'h0, 32'h0, 32'h0);
      step_pixel();
   endtask

   // Loads the top and bottom words of the RAM, then runs a span off the right
   // edge of the last row of page one. The texel address wraps through the top
   // of the RAM, the stop saturates at the row width, zero texels leave holes,
   // and the palette sum wraps.
   task automatic test_wraps_and_skips();
      load_texture(19'h7ffff, 16'h00a5);
      load_texture(19'h00000, 16'h5a00);
      configure(16'hfff0, 8'hff, tspf_pkg::MODE_TRANSPARENT, 1'b0, 16'hffff, 1'b1);
      open_span(9'd511, 9'd508, 10'd1023, 32'h00fe_0000, 32'h0, 32'h0001_0000, 32'h0);
      repeat (4) step_pixel();
      step_pixel();
   endtask

   // A span is replaced while still active by a one-pixel span at the far edge
   // whose u is just below zero.
   task automatic test_span_replace();
      configure(16'h1234, 8'h0f, tspf_pkg::MODE_TEXTURED, 1'b0, 16'h0000, 1'b0);
      open_span(9'd0, 9'd0, 10'd512, 32'h0, 32'h0, 32'h0000_8000, 32'h0);
      repeat (2) step_pixel();
      open_span(9'd5, 9'd511, 10'd512, 32'hffff_0000, 32'h00ff_0000, 32'h0, 32'h0);
      step_pixel();
   endtask

   // Masked mode with the checkerboard on: row and start disagree in parity, so
   // the start moves by one and the coordinates by one step before the first pixel.
   task automatic test_dither_alignment();
      configure(16'h0000, 8'h7f, tspf_pkg::MODE_MASKED, 1'b1, 16'h0010, 1'b0);
      open_span(9'd3, 9'd4, 10'd12, 32'h0010_0000, 32'h0, 32'hffff_0000, 32'h0001_0000);
      while (span_live) step_pixel();
   endtask

   // Random traffic under each idling pattern in turn: none, a mostly idle
   // sender, a mostly stalled receiver, and light idling on both sides.
   task automatic test_random_traffic();
      idle_pct  = 0;
      stall_pct = 0;
      run_traffic(240);
      idle_pct  = 80;
      run_traffic(230);
      idle_pct  = 0;
      stall_pct = 80;
      run_traffic(240);
      idle_pct  = 25;
      stall_pct = 25;
      run_traffic(240);
   endtask

   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_ignored();
      test_wraps_and_skips();
      test_span_replace();
      test_dither_alignment();
      test_random_traffic();
      wait_quiet();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
